// ===== design/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg
// shared constants and control types for the sync / length / checksum deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  // default frame store depth
  localparam int MAX_FRAME_DEF = 32;

  // configuration register reset values
  localparam logic [7:0] SYNC_RST = 8'hFA;
  localparam logic [5:0] MIN_RST  = 6'd10;
  localparam logic [5:0] MAX_RST  = 6'd28;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  // smallest legal frame: sync, length, checksum
  localparam logic [7:0] MIN_FRAME = 8'd3;

  // controller to datapath commands
  typedef struct packed {
    logic start_frame;   // store sync byte, restart sum and count
    logic take_len;      // store length byte, latch expected length
    logic body_wr;       // store a body byte
    logic body_acc;      // add body byte to sum, advance count
    logic load_len_err;  // present a length error result
    logic load_csum_err; // present a checksum error result
    logic rd_start;      // clear replay index
    logic rd_issue;      // read frame store at replay index
    logic rd_load;       // present replayed byte, advance replay index
  } slcd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_sync;   // input byte matches sync value
    logic len_ok;    // input byte is an acceptable length
    logic last_pos;  // input byte is the checksum byte
    logic sum_ok;    // input byte equals running sum
    logic pos_ovf;   // store position beyond the frame store
    logic rd_last;   // replay index is on the final byte
    logic out_free;  // output register can take a result this cycle
  } slcd_sts_t;

endpackage

`default_nettype wire

// ===== design/sync_length_checksum_deframer.sv =====
// an error result is registered and valid the cycle after the byte that caused it; a good
// frame is replayed after its checksum, each byte by a registered frame store read, then a
// result load; one byte per cycle is taken while hunting and collecting unless the result
// register is full and stalled, and no bytes are taken while a frame is replayed
// reset: synchronous active-low rst_n; configuration returns to sync 0xfa,
// lengths 10 to 28, the block hunts for sync and the result register is empty
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// hunts for a sync byte, checks frame length and additive checksum, and
// replays good frames byte by byte or reports one error result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  // received bytes
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_frame_byte,
  output logic [4:0]                out_byte_index,
  output logic [5:0]                out_frame_length,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  slcd_cmd_t cmd;
  slcd_sts_t sts;

  // registers are plain flops, a write always lands at once
  assign cfg_ready = 1'b1;

  // controller: phase tracking and replay sequencing; it also holds off new
  // items while a frame is replayed or the result register is full and stalled
  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: configuration registers, frame store memory, running sum,
  // byte count, expected length, replay index and the result register
  slcd_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== design/slcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcd_ctrl
// frame state machine: hunting, length, body collection and frame replay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcd_ctrl
  import slcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire slcd_sts_t sts,
  output slcd_cmd_t      cmd
);

  localparam logic [2:0] S_HUNT = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_BODY = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_fire;

  // no new item during replay or while the result slot is full and stalled
  assign in_stall = (state_r == S_RD) || (state_r == S_WR) || !sts.out_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LEN: begin
        if (in_fire) begin
          if (!sts.len_ok) begin
            cmd.load_len_err = 1'b1;
            if (sts.is_sync) begin
              cmd.start_frame = 1'b1;
              state_nxt       = S_LEN;
            end else begin
              state_nxt = S_HUNT;
            end
          end else begin
            cmd.take_len = 1'b1;
            state_nxt    = S_BODY;
          end
        end
      end
      S_BODY: begin
        if (in_fire) begin
          if (sts.pos_ovf) begin
            state_nxt = S_HUNT;
          end else if (sts.last_pos) begin
            cmd.body_wr = 1'b1;
            if (sts.sum_ok) begin
              cmd.rd_start = 1'b1;
              state_nxt    = S_RD;
            end else begin
              cmd.load_csum_err = 1'b1;
              state_nxt         = S_HUNT;
            end
          end else begin
            cmd.body_wr  = 1'b1;
            cmd.body_acc = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = sts.rd_last ? S_HUNT : S_RD;
        end
      end
      default: begin
        // hunting, and any unused code
        if (in_fire) begin
          if (sts.is_sync) begin
            cmd.start_frame = 1'b1;
            state_nxt       = S_LEN;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/slcd_dp.sv =====
// ----------------------------------------------------------------------------
// slcd_dp
// configuration, frame store, running sum, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcd_dp
  import slcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic [7:0]           in_rx_byte,
  input  wire slcd_cmd_t            cmd,
  output slcd_sts_t                 sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_frame_byte,
  output logic [4:0]                out_byte_index,
  output logic [5:0]                out_frame_length,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  localparam int AW    = $clog2(MAX_FRAME);
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [7:0]       MAX_B = 8'(MAX_FRAME);
  localparam logic [7:0]       CAP_B = 8'((MAX_FRAME > 63) ? 63 : MAX_FRAME);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAME);

  // configuration
  logic [7:0] sync_r;
  logic [5:0] min_r;
  logic [5:0] max_r;

  // frame tracking
  logic [CNT_W-1:0] taken_r,  taken_nxt;
  logic [CNT_W-1:0] exp_r,    exp_nxt;
  logic [7:0]       sum_r,    sum_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;

  // frame store
  logic [7:0]    mem [MAX_FRAME];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // result register
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r;
  logic [4:0] oidx_r;
  logic [5:0] olen_r;
  logic [1:0] ost_r;
  logic       olast_r;
  logic [7:0] clip;
  logic       load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RST;
      min_r  <= MIN_RST;
      max_r  <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC: sync_r <= cfg_data;
        CFG_MIN:  min_r  <= cfg_data[5:0];
        CFG_MAX:  max_r  <= cfg_data[5:0];
        default:  ;
      endcase
    end
  end

  assign sts.is_sync  = (in_rx_byte == sync_r);
  assign sts.len_ok   = (in_rx_byte >= MIN_FRAME) && (in_rx_byte >= {2'b00, min_r}) &&
                        (in_rx_byte <= {2'b00, max_r}) && (in_rx_byte <= MAX_B);
  assign sts.last_pos = ((CNT_W+1)'(taken_r) + 1'b1) >= (CNT_W+1)'(exp_r);
  assign sts.sum_ok   = (sum_r == in_rx_byte);
  assign sts.pos_ovf  = (taken_r >= MAX_C);
  assign sts.rd_last  = ((CNT_W+1)'(rd_idx_r) + 1'b1) == (CNT_W+1)'(exp_r);
  assign sts.out_free = !oval_r || !out_stall;

  always_comb begin
    taken_nxt  = taken_r;
    exp_nxt    = exp_r;
    sum_nxt    = sum_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.start_frame) begin
      taken_nxt = CNT_W'(1);
      exp_nxt   = '0;
      sum_nxt   = in_rx_byte;
    end else if (cmd.take_len) begin
      taken_nxt = CNT_W'(2);
      exp_nxt   = in_rx_byte[CNT_W-1:0];
      sum_nxt   = sum_r + in_rx_byte;
    end else if (cmd.body_acc) begin
      taken_nxt = taken_r + 1'b1;
      sum_nxt   = sum_r + in_rx_byte;
    end
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_load) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= '0;
      exp_r    <= '0;
      sum_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      taken_r  <= taken_nxt;
      exp_r    <= exp_nxt;
      sum_r    <= sum_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // sync byte always lands at entry zero, later bytes at the running count
  assign wr_en   = cmd.start_frame || cmd.take_len || cmd.body_wr;
  assign wr_addr = cmd.start_frame ? '0 : taken_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  assign clip = (in_rx_byte > CAP_B) ? CAP_B : in_rx_byte;
  assign load = cmd.load_len_err || cmd.load_csum_err || cmd.rd_load;

  always_comb begin
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len_err) begin
      obyte_r <= '0;
      oidx_r  <= '0;
      olen_r  <= clip[5:0];
      ost_r   <= ST_LEN;
      olast_r <= 1'b1;
    end else if (cmd.load_csum_err) begin
      obyte_r <= '0;
      oidx_r  <= '0;
      olen_r  <= 6'(exp_r);
      ost_r   <= ST_CSUM;
      olast_r <= 1'b1;
    end else if (cmd.rd_load) begin
      obyte_r <= rd_data_r;
      oidx_r  <= 5'(rd_idx_r);
      olen_r  <= 6'(exp_r);
      ost_r   <= ST_GOOD;
      olast_r <= sts.rd_last;
    end
  end

  assign out_valid        = oval_r;
  assign out_frame_byte   = obyte_r;
  assign out_byte_index   = oidx_r;
  assign out_frame_length = olen_r;
  assign out_status       = ost_r;
  assign out_last         = olast_r;

endmodule

`default_nettype wire

// ===== bench/deframer_checker.sv =====
// ----------------------------------------------------------------------------
// deframer_checker
// watches the configuration, byte and result channels of the deframer, works
// out the results each received byte should give and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframer_checker
  import slcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [7:0]           out_frame_byte,
  input  wire logic [4:0]           out_byte_index,
  input  wire logic [5:0]           out_frame_length,
  input  wire logic [1:0]           out_status,
  input  wire logic                 out_last,
  output int                        mismatches,
  output int                        awaited
);

  typedef enum logic [1:0] {SEEK_SYNC, SEEK_LEN, COLLECT} hunt_state_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [4:0] idx;
    logic [5:0] flen;
    logic [1:0] status;
    logic       last;
  } frame_result_t;

  logic [7:0]    sync_byte;
  logic [5:0]    len_floor;
  logic [5:0]    len_ceil;
  hunt_state_t   hunt;
  logic [7:0]    frame_buf [0:MAX_FRAME-1];
  logic [5:0]    taken;
  logic [7:0]    want_len;
  logic [7:0]    csum;
  frame_result_t due_results [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic begin_frame(input logic [7:0] b);
    frame_buf[0] = b;
    csum         = b;
    taken        = 6'd1;
    want_len     = 8'd0;
    hunt         = SEEK_LEN;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int            cap;
    int            pos;
    case (hunt)
      SEEK_LEN: begin
        if (b < MIN_FRAME || b < len_floor || b > len_ceil || b > MAX_FRAME) begin
          cap      = (MAX_FRAME > 63) ? 63 : MAX_FRAME;
          r.fbyte  = 8'd0;
          r.idx    = 5'd0;
          r.flen   = (b > cap) ? 6'(cap) : b[5:0];
          r.status = ST_LEN;
          r.last   = 1'b1;
          due_results.push_back(r);
          // a rejected length that happens to be the sync byte opens a new frame
          if (b == sync_byte) begin_frame(b);
          else hunt = SEEK_SYNC;
        end else begin
          frame_buf[1] = b;
          csum         = csum + b;
          taken        = 6'd2;
          want_len     = b;
          hunt         = COLLECT;
        end
      end
      COLLECT: begin
        pos = taken;
        if (pos >= MAX_FRAME || want_len > MAX_FRAME || want_len < MIN_FRAME) begin
          hunt = SEEK_SYNC;
        end else begin
          frame_buf[pos] = b;
          if (pos + 1 >= want_len) begin
            hunt = SEEK_SYNC;
            if (csum == b) begin
              for (int i = 0; i < want_len; i++) begin
                r.fbyte  = frame_buf[i];
                r.idx    = 5'(i);
                r.flen   = 6'(want_len);
                r.status = ST_GOOD;
                r.last   = (i + 1 == want_len);
                due_results.push_back(r);
              end
            end else begin
              r.fbyte  = 8'd0;
              r.idx    = 5'd0;
              r.flen   = 6'(want_len);
              r.status = ST_CSUM;
              r.last   = 1'b1;
              due_results.push_back(r);
            end
          end else begin
            csum  = csum + b;
            taken = 6'(pos + 1);
          end
        end
      end
      default: begin
        if (b == sync_byte) begin_frame(b);
        else hunt = SEEK_SYNC;
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      sync_byte  = SYNC_RST;
      len_floor  = MIN_RST;
      len_ceil   = MAX_RST;
      hunt       = SEEK_SYNC;
      taken      = 6'd0;
      want_len   = 8'd0;
      csum       = 8'd0;
      mismatches = 0;
      due_results.delete();
    end else begin
      // results leave before the byte of this edge is looked at
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing awaited, status", out_status, 0);
        end else begin
          want = due_results.pop_front();
          if (out_frame_byte !== want.fbyte)
            report_mismatch("frame_byte", out_frame_byte, want.fbyte);
          if (out_byte_index !== want.idx)
            report_mismatch("byte_index", out_byte_index, want.idx);
          if (out_frame_length !== want.flen)
            report_mismatch("frame_length", out_frame_length, want.flen);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC: sync_byte = cfg_data;
          CFG_MIN:  len_floor = cfg_data[5:0];
          CFG_MAX:  len_ceil  = cfg_data[5:0];
          default:  ;
        endcase
      end
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
    awaited = due_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives received bytes and configuration writes into the deframer, stalls
// the result side at random and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import slcd_pkg::*;

  localparam int MAX_FRAME = MAX_FRAME_DEF;
  // index with no register behind it, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS   = 450;
  localparam int PHASES         = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_SYNC;
  logic [7:0]           cfg_data   = 8'd0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'd0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [7:0]           out_frame_byte;
  logic [4:0]           out_byte_index;
  logic [5:0]           out_frame_length;
  logic [1:0]           out_status;
  logic                 out_last;

  int  mismatches;
  int  awaited;
  int  sent        = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;   // no idling on either side in the closing phase
  bit  hold_req    = 1'b0;   // asks the receiver for one long hold-off

  // register values as last written, used to shape frames
  logic [7:0] cur_sync = SYNC_RST;
  logic [5:0] cur_min  = MIN_RST;
  logic [5:0] cur_max  = MAX_RST;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sync_length_checksum_deframer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  deframer_checker #(
    .MAX_FRAME (MAX_FRAME)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_status       (out_status),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .awaited          (awaited)
  );

  // offer one item; valid stays up from item to item unless a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // length byte, payload and checksum of a frame whose sync byte has gone out
  task automatic send_rest(input logic [7:0] n, input bit spoil);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cur_sync + n;
    send_byte(n);
    for (int k = 2; k < n - 1; k++) begin
      b   = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    // a broken frame gets one checksum bit flipped
    if (spoil) sum = sum ^ 8'(1 << $urandom_range(0, 7));
    send_byte(sum);
  endtask

  // a length byte the block must reject, kept off the sync value
  function automatic logic [7:0] pick_bad_length(input int lo, input int hi);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
    end while ((b >= lo && b <= hi) || b == cur_sync);
    return b;
  endfunction

  // one unit of random traffic: mostly whole frames, some noise and breakage
  task automatic send_random_unit();
    int lo;
    int hi;
    int pick;
    int n;
    lo   = (cur_min > MIN_FRAME) ? cur_min : MIN_FRAME;
    hi   = (cur_max < MAX_FRAME) ? cur_max : MAX_FRAME;
    pick = $urandom_range(0, 99);
    if (pick < 70 && lo <= hi) begin
      // short frames most of the time, the full accepted range now and then
      if ($urandom_range(0, 4) != 0) n = $urandom_range(lo, (hi < lo + 5) ? hi : lo + 5);
      else n = $urandom_range(lo, hi);
      send_byte(cur_sync);
      send_rest(8'(n), pick >= 55);
    end else if (pick < 85 || (pick < 70 && lo > hi)) begin
      send_byte(cur_sync);
      send_byte(pick_bad_length(lo, hi));
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      // sync byte where the length should be
      send_byte(cur_sync);
      send_byte(cur_sync);
    end
  endtask

  // wait for the block to go quiet before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_SYNC: cur_sync = val;
      CFG_MIN:  cur_min  = val[5:0];
      CFG_MAX:  cur_max  = val[5:0];
      default:  ;
    endcase
  endtask

  task automatic configure(input logic [7:0] sync_val, input logic [7:0] min_val,
                           input logic [7:0] max_val, input bit spare);
    write_reg(CFG_SYNC, sync_val);
    write_reg(CFG_MIN, min_val);
    write_reg(CFG_MAX, max_val);
    if (spare) write_reg(CFG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: free runs and stall bursts of random length, one long hold
  // when asked, nothing but free running in the closing phase
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else if ($urandom_range(0, 4) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  // watchdog: too long without any handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles, %0d results awaited",
               idle_cycles, awaited);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int quota;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise extremes, then under the reset settings a too-short
    // length, a rejected length equal to sync that opens a frame at once,
    // and a good minimum-length frame from that restarted sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync);
    send_byte(8'd2);
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_rest(8'(MIN_RST), 1'b0);
    settle();
    // shortest legal frame and a broken checksum, upper data bits set
    configure(SYNC_RST, {2'b11, 6'd3}, {2'b10, 6'd32}, 1'b0);
    send_byte(cur_sync);
    send_rest(8'd3, 1'b0);
    send_byte(cur_sync);
    send_rest(8'd5, 1'b1);

    for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
      settle();
      case (phase_no)
        0: configure(8'h00, {2'($urandom), 6'd3}, {2'($urandom), 6'd32}, 1'b0);
        1: configure(8'hFF, 8'd3, 8'd3, 1'b0);
        2: configure(8'($urandom), 8'd32, 8'd32, 1'b0);
        // register limits wider than the block: min 0, max 63
        3: configure(8'($urandom), 8'hC0, 8'hFF, 1'b0);
        4: configure(8'($urandom), 8'd20, 8'd32, 1'b0);
        // min above max, nothing can pass; also a write to the spare index
        5: configure(8'($urandom), 8'd25, 8'd7, 1'b1);
        6: configure(SYNC_RST, {2'b00, MIN_RST}, {2'b00, MAX_RST}, 1'b0);
        default: configure(8'($urandom), {2'($urandom), 6'($urandom_range(3, 32))},
                           {2'($urandom), 6'($urandom_range(3, 32))},
                           $urandom_range(0, 1) != 0);
      endcase
      // long frames against a held-off receiver fill the block up
      if (phase_no == 4) hold_req = 1'b1;
      if (phase_no == PHASES - 1) calm = 1'b1;
      quota = sent + RANDOM_ITEMS / PHASES;
      while (sent < quota) send_random_unit();
    end

    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
design/slcd_pkg.sv
design/slcd_ctrl.sv
design/slcd_dp.sv
design/sync_length_checksum_deframer.sv
bench/deframer_checker.sv
bench/testbench.sv
